// File: sv/pwcd_pkg.sv
// Package for the pulse-width command decoder: opcodes, command codes, band limits,
// register indexes, reset values and the shared struct types.
// Depends on nothing; every other file of the block imports it.
package pwcd_pkg;

  // Input opcodes. The fourth code is ignored by the decoder.
  localparam logic [1:0] OP_RISE = 2'd0;
  localparam logic [1:0] OP_FALL = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // Command codes on the result channel.
  localparam logic [1:0] CMD_LINK = 2'd0;
  localparam logic [1:0] CMD_DOWN = 2'd1;
  localparam logic [1:0] CMD_UP   = 2'd2;

  // Band markers in the upper nibble of the last-hit tag.
  localparam logic [7:0] TAG_DOWN      = 8'h10;
  localparam logic [7:0] TAG_UP        = 8'h20;
  localparam logic [7:0] TAG_LINK      = 8'h40;
  localparam logic [7:0] TAG_BAND_MASK = 8'hF0;

  // Exclusive band limits in milliseconds.
  localparam logic [15:0] LINK_LO = 16'd70;
  localparam logic [15:0] LINK_HI = 16'd150;
  localparam logic [15:0] DOWN_LO = 16'd170;
  localparam logic [15:0] DOWN_HI = 16'd250;
  localparam logic [15:0] UP_LO   = 16'd270;
  localparam logic [15:0] UP_HI   = 16'd360;

  // The tick advances the stale window by this many milliseconds.
  localparam logic [16:0] TICK_STEP_MS = 17'd10;
  localparam logic [3:0]  COUNT_MAX    = 4'd15;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_DECODE_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_WINDOW_MS  = 2'd2;

  // Register reset values.
  localparam logic        RST_DECODE_ENABLE    = 1'b0;
  localparam logic [3:0]  RST_REPEAT_THRESHOLD = 4'd5;
  localparam logic [15:0] RST_STALE_WINDOW_MS  = 16'd1000;

  typedef struct packed {
    logic        decode_enable;
    logic [3:0]  repeat_threshold;
    logic [15:0] stale_window_ms;
  } cfg_t;

  typedef struct packed {
    logic        armed;
    logic [15:0] start_time;
    logic [3:0]  link_count;
    logic [3:0]  down_count;
    logic [3:0]  up_count;
    logic [7:0]  last_tag;
    logic [7:0]  tag_snapshot;
    logic [15:0] window_ms;
  } state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] time_ms;
  } item_t;

  typedef struct packed {
    logic        command_fired;
    logic [1:0]  command_code;
    logic [15:0] pulse_width;
  } result_t;

endpackage

// File: sv/pwcd_if.sv
// Stream and configuration interfaces of the pulse-width command decoder.
// Depends on pwcd_pkg for the configuration widths.

interface pwcd_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] time_ms;
  modport source (output valid, output opcode, output time_ms, input ready);
  modport sink   (input valid, input opcode, input time_ms, output ready);
endinterface

interface pwcd_result_if;
  logic        valid;
  logic        ready;
  logic        command_fired;
  logic [1:0]  command_code;
  logic [15:0] pulse_width;
  modport source (output valid, output command_fired, output command_code,
                  output pulse_width, input ready);
  modport sink   (input valid, input command_fired, input command_code,
                  input pulse_width, output ready);
endinterface

interface pwcd_cfg_if;
  import pwcd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/pwcd_core.sv
// Next-state and result logic of the pulse-width command decoder for one item.
// Depends on pwcd_pkg for the state, configuration and result structs.
module pwcd_core (
  input  pwcd_pkg::state_t  state_i,
  input  pwcd_pkg::cfg_t    cfg_i,
  input  pwcd_pkg::item_t   item_i,
  output pwcd_pkg::state_t  state_o,
  output pwcd_pkg::result_t result_o
);
  import pwcd_pkg::*;

  typedef struct packed {
    logic       fire;
    logic [3:0] count;
  } band_t;

  // A hit fires when the counter already exceeds the threshold, then restarts.
  function automatic band_t band_step(input logic [3:0] count, input logic [3:0] thr);
    band_t r;
    r.fire  = (count > thr);
    r.count = r.fire ? 4'd1 : ((count < COUNT_MAX) ? count + 4'd1 : COUNT_MAX);
    return r;
  endfunction

  logic [15:0] width;
  logic        in_link, in_down, in_up;
  band_t       link_hit, down_hit, up_hit;
  logic        window_over;
  logic [15:0] window_base;
  logic [16:0] window_sum;

  assign width    = item_i.time_ms - state_i.start_time;
  assign in_link  = (width > LINK_LO) && (width < LINK_HI);
  assign in_down  = (width > DOWN_LO) && (width < DOWN_HI);
  assign in_up    = (width > UP_LO) && (width < UP_HI);
  assign link_hit = band_step(state_i.link_count, cfg_i.repeat_threshold);
  assign down_hit = band_step(state_i.down_count, cfg_i.repeat_threshold);
  assign up_hit   = band_step(state_i.up_count, cfg_i.repeat_threshold);

  assign window_over = state_i.window_ms > cfg_i.stale_window_ms;
  assign window_base = window_over ? 16'd0 : state_i.window_ms;
  assign window_sum  = {1'b0, window_base} + TICK_STEP_MS;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    unique case (item_i.opcode)
      OP_RISE: begin
        if (!state_i.armed) begin
          state_o.armed      = 1'b1;
          state_o.start_time = item_i.time_ms;
        end
      end
      OP_FALL: begin
        if (state_i.armed) begin
          state_o.armed        = 1'b0;
          result_o.pulse_width = width;
          if (cfg_i.decode_enable) begin
            if (in_link) begin
              state_o.down_count     = '0;
              state_o.up_count       = '0;
              state_o.link_count     = link_hit.count;
              state_o.last_tag       = TAG_LINK | {4'd0, link_hit.count};
              result_o.command_fired = link_hit.fire;
              result_o.command_code  = CMD_LINK;
            end else if (in_down) begin
              state_o.link_count     = '0;
              state_o.up_count       = '0;
              state_o.down_count     = down_hit.count;
              state_o.last_tag       = TAG_DOWN | {4'd0, down_hit.count};
              result_o.command_fired = down_hit.fire;
              result_o.command_code  = down_hit.fire ? CMD_DOWN : CMD_LINK;
            end else if (in_up) begin
              state_o.link_count     = '0;
              state_o.down_count     = '0;
              state_o.up_count       = up_hit.count;
              state_o.last_tag       = TAG_UP | {4'd0, up_hit.count};
              result_o.command_fired = up_hit.fire;
              result_o.command_code  = up_hit.fire ? CMD_UP : CMD_LINK;
            end
          end
        end
      end
      OP_TICK: begin
        if (window_over) begin
          if (state_i.tag_snapshot == state_i.last_tag) begin
            case (state_i.last_tag & TAG_BAND_MASK)
              TAG_DOWN: state_o.down_count = '0;
              TAG_UP:   state_o.up_count   = '0;
              TAG_LINK: state_o.link_count = '0;
              default:  ;
            endcase
            state_o.last_tag = '0;
          end
          state_o.tag_snapshot = state_o.last_tag;
        end
        state_o.window_ms = window_sum[16] ? 16'hFFFF : window_sum[15:0];
      end
      default: ;
    endcase
  end

endmodule

// File: sv/pulse_width_command_decoder_unit.sv
// Top level of the pulse-width command decoder: handshakes, configuration
// registers, decoder state and the two pipeline registers.
// Depends on pwcd_pkg, the interfaces in pwcd_if.sv and pwcd_core.

// The decoder takes one transaction per clock on the item channel unless
// the sink stalls: a rising edge, a falling edge or a 10 ms tick, each with
// its millisecond timestamp. Every item yields exactly one result
// transaction: the item is first captured in an input register, then the
// decoder state and the result register are updated together once it is
// free. Throughput is one item per cycle; it is set by the combinational
// state update in pwcd_core, and the result register lets a new item enter
// while an earlier result still waits for the sink. A falling edge that
// follows a rising edge reports the pulse width modulo 2^16 ms; when
// decoding is enabled the width may also complete a link, key-down or
// key-up command once its band counter has exceeded the repeat threshold.
// Configuration writes are always accepted and must only be issued while
// no item is in flight; writes to an unknown index are ignored.
module pulse_width_command_decoder_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  pwcd_item_if.sink          item_i,
  pwcd_result_if.source      result_o,
  pwcd_cfg_if.sink           cfg_i
);
  import pwcd_pkg::*;

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  item_t   item_q;
  logic    item_vld_q;
  result_t res_q, res_d;
  logic    res_vld_q;
  logic    advance;

  // The input register moves into the result register whenever the result
  // register is empty or its content is being taken this cycle.
  assign advance      = item_vld_q && (!res_vld_q || result_o.ready);
  assign item_i.ready = !item_vld_q || advance;
  assign cfg_i.ready  = 1'b1;

  // Configuration registers. The enable and threshold keep only low data bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decode_enable    <= RST_DECODE_ENABLE;
      cfg_q.repeat_threshold <= RST_REPEAT_THRESHOLD;
      cfg_q.stale_window_ms  <= RST_STALE_WINDOW_MS;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_DECODE_ENABLE:    cfg_q.decode_enable    <= cfg_i.data[0];
        REG_REPEAT_THRESHOLD: cfg_q.repeat_threshold <= cfg_i.data[3:0];
        REG_STALE_WINDOW_MS:  cfg_q.stale_window_ms  <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  // Input register. The payload needs no reset; only its valid flag does.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (item_i.ready) begin
      item_vld_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.ready && item_i.valid) begin
      item_q.opcode  <= item_i.opcode;
      item_q.time_ms <= item_i.time_ms;
    end
  end

  pwcd_core u_core (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Decoder state is committed in the same cycle the result is registered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid         = res_vld_q;
  assign result_o.command_fired = res_q.command_fired;
  assign result_o.command_code  = res_q.command_code;
  assign result_o.pulse_width   = res_q.pulse_width;

endmodule
